>>> hw/rtl/rc5_ir_frame_decoder_top_assert.svh
// Assertion macros for the checker file rc5_dec_checker.sv.
`ifndef RC5_IR_FRAME_DECODER_TOP_ASSERT_SVH
`define RC5_IR_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RC5_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RC5_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rc5_dec_pkg.sv
`timescale 1ns / 1ps

package rc5_dec_pkg;

    localparam int TICK_W    = 16;
    localparam int ADDR_BITS = 5;
    localparam int CMD_BITS  = 6;
    localparam int FRAME_W   = ADDR_BITS + CMD_BITS;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_BIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_DIS   = 2'd3;

    // reset values of the config registers
    localparam logic [TICK_W-1:0] RST_HALF_BIT  = 16'd111;
    localparam logic [TICK_W-1:0] RST_FULL_BIT  = 16'd222;
    localparam logic [TICK_W-1:0] RST_TOLERANCE = 16'd32;

    // input item kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START2,
        PH_TOGGLE,
        PH_ADDR,
        PH_CMD
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] half_bit;
        logic [TICK_W-1:0] full_bit;
        logic [TICK_W-1:0] tolerance;
        logic              rep_dis;
    } t_cfg;

    // what the decoder reports for one edge beat
    typedef struct packed {
        logic               frame_new;
        logic               repeat_seen;
        logic [FRAME_W-1:0] frame;
        logic [CNT_W-1:0]   repeat_count;
    } t_dec_evt;

    // result beat without the popped frame fields
    typedef struct packed {
        logic             frame_stored;
        logic             repeat_seen;
        logic             read_valid;
        logic             fifo_nonempty;
        logic [CNT_W-1:0] repeat_count;
    } t_result;

endpackage

>>> hw/rtl/rc5_ir_frame_decoder_top.sv
`timescale 1ns / 1ps

// RC5 infrared frame decoder with a frame ring FIFO.
// Input channel (i_valid / o_stall): each beat is either a line edge
// (i_kind = 0, with i_elapsed_ticks since the previous edge and i_level_low)
// or a read request (i_kind = 1) that pops one decoded frame.
// Output channel (o_valid / i_stall): exactly one result beat per input
// beat, in order: frame stored / repeat flags, the popped address and
// command, FIFO non-empty status and the repeat count.
// Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (0 half bit, 1 full bit, 2 tolerance, 3 repeats disabled); write only
// while no beats are in flight.
// Throughput is one beat per cycle while the receiver does not stall; the
// decode is a single pass of compares and shifts. The decode result and the
// FIFO RAM read are registered in the inner stage, then in the output register.
// When the receiver stalls, the output register holds and one more beat is
// taken into the inner stage; o_stall rises only when both are full.
// Synchronous reset clears the decoder, the FIFO pointers, the config
// registers to their defaults and both result stages. FIFO contents are
// not cleared; only written entries are ever read.
module rc5_ir_frame_decoder_top #(
    parameter int FIFO_DEPTH    = 8,
    parameter int TIMEOUT_TICKS = 13056
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_kind,
    input  logic [rc5_dec_pkg::TICK_W-1:0]         i_elapsed_ticks,
    input  logic                                   i_level_low,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_frame_stored,
    output logic                                   o_repeat_seen,
    output logic                                   o_read_valid,
    output logic [rc5_dec_pkg::ADDR_BITS-1:0]      o_address,
    output logic [rc5_dec_pkg::CMD_BITS-1:0]       o_command,
    output logic                                   o_fifo_nonempty,
    output logic [rc5_dec_pkg::CNT_W-1:0]          o_repeat_count,
    input  logic                                   i_cfg_we,
    input  logic [rc5_dec_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rc5_dec_pkg::TICK_W-1:0]         i_cfg_wdata
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    rc5_dec_pkg::t_cfg       r_cfg;
    logic [PTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic                    ready;
    logic                    accept;
    logic                    edge_fire;
    logic                    pop;
    logic                    push;
    rc5_dec_pkg::t_dec_evt   evt;
    rc5_dec_pkg::t_result    res;
    rc5_dec_pkg::t_result    out_res;
    logic [rc5_dec_pkg::FRAME_W-1:0] rdata;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit  <= rc5_dec_pkg::RST_HALF_BIT;
            r_cfg.full_bit  <= rc5_dec_pkg::RST_FULL_BIT;
            r_cfg.tolerance <= rc5_dec_pkg::RST_TOLERANCE;
            r_cfg.rep_dis   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rc5_dec_pkg::REG_HALF_BIT:  r_cfg.half_bit  <= i_cfg_wdata;
                rc5_dec_pkg::REG_FULL_BIT:  r_cfg.full_bit  <= i_cfg_wdata;
                rc5_dec_pkg::REG_TOLERANCE: r_cfg.tolerance <= i_cfg_wdata;
                rc5_dec_pkg::REG_REP_DIS:   r_cfg.rep_dis   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_stall   = !ready;
    assign accept    = i_valid && ready;
    assign edge_fire = accept && (i_kind == rc5_dec_pkg::KIND_EDGE);
    assign pop       = accept && (i_kind == rc5_dec_pkg::KIND_READ) && (r_rd_ptr != r_wr_ptr);
    assign push      = edge_fire && evt.frame_new;

    rc5_dec_core #(
        .TIMEOUT_TICKS (TIMEOUT_TICKS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (edge_fire),
        .i_elapsed_ticks (i_elapsed_ticks),
        .i_level_low     (i_level_low),
        .i_cfg           (r_cfg),
        .o_evt           (evt)
    );

    // ring pointers, no full check: a push may overrun the reader
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
        end
    end

    rc5_dec_ram #(
        .WIDTH (rc5_dec_pkg::FRAME_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_wr_ptr),
        .i_wdata (evt.frame),
        .i_re    (pop),
        .i_raddr (r_rd_ptr),
        .o_rdata (rdata)
    );

    // result beat of the accepted item
    always_comb begin
        res.frame_stored  = edge_fire && evt.frame_new;
        res.repeat_seen   = edge_fire && evt.repeat_seen;
        res.read_valid    = pop;
        res.fifo_nonempty = (n_rd_ptr != n_wr_ptr);
        res.repeat_count  = evt.repeat_count;
    end

    rc5_dec_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (accept),
        .i_res     (res),
        .i_rdata   (rdata),
        .i_stall   (i_stall),
        .o_ready   (ready),
        .o_valid   (o_valid),
        .o_res     (out_res),
        .o_address (o_address),
        .o_command (o_command)
    );

    assign o_frame_stored  = out_res.frame_stored;
    assign o_repeat_seen   = out_res.repeat_seen;
    assign o_read_valid    = out_res.read_valid;
    assign o_fifo_nonempty = out_res.fifo_nonempty;
    assign o_repeat_count  = out_res.repeat_count;

endmodule

>>> hw/rtl/rc5_dec_ram.sv
`timescale 1ns / 1ps

module rc5_dec_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/rc5_dec_core.sv
`timescale 1ns / 1ps

module rc5_dec_core #(
    parameter int TIMEOUT_TICKS = 13056
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic [rc5_dec_pkg::TICK_W-1:0]      i_elapsed_ticks,
    input  logic                                i_level_low,
    input  rc5_dec_pkg::t_cfg                   i_cfg,
    output rc5_dec_pkg::t_dec_evt               o_evt
);

    localparam int TW = rc5_dec_pkg::TICK_W;
    localparam logic [TW-1:0] TIMEOUT = TW'(TIMEOUT_TICKS);

    rc5_dec_pkg::t_phase r_phase, n_phase;
    logic [TW-1:0]                          r_interval, n_interval;
    logic [2:0]                             r_bit_index, n_bit_index;
    logic [rc5_dec_pkg::ADDR_BITS-1:0]      r_addr_shift, n_addr_shift;
    logic [rc5_dec_pkg::CMD_BITS-1:0]       r_cmd_shift, n_cmd_shift;
    logic                                   r_toggle_now, n_toggle_now;
    logic                                   r_toggle_prev, n_toggle_prev;
    logic [rc5_dec_pkg::CNT_W-1:0]          r_rep_cnt, n_rep_cnt;

    rc5_dec_pkg::t_phase eff_phase;
    logic [TW:0]   sum;
    logic [TW-1:0] sat;
    logic          full_hit;
    logic          half_hit;
    logic [3:0]    addr_next;
    logic [2:0]    cmd_next;
    logic          frame_new;
    logic          repeat_seen;

    // decoder state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= rc5_dec_pkg::PH_IDLE;
            r_interval    <= '0;
            r_bit_index   <= '0;
            r_addr_shift  <= '0;
            r_cmd_shift   <= '0;
            r_toggle_now  <= 1'b0;
            r_toggle_prev <= 1'b0;
            r_rep_cnt     <= '0;
        end else begin
            r_phase       <= n_phase;
            r_interval    <= n_interval;
            r_bit_index   <= n_bit_index;
            r_addr_shift  <= n_addr_shift;
            r_cmd_shift   <= n_cmd_shift;
            r_toggle_now  <= n_toggle_now;
            r_toggle_prev <= n_toggle_prev;
            r_rep_cnt     <= n_rep_cnt;
        end
    end

    // timeout, saturating interval and period matching
    always_comb begin
        eff_phase = (i_elapsed_ticks >= TIMEOUT) ? rc5_dec_pkg::PH_IDLE : r_phase;
        sum       = {1'b0, r_interval} + {1'b0, i_elapsed_ticks};
        sat       = sum[TW] ? '1 : sum[TW-1:0];
        full_hit  = (({1'b0, sat} + {1'b0, i_cfg.tolerance}) > {1'b0, i_cfg.full_bit}) &&
                    ({1'b0, sat} < ({1'b0, i_cfg.full_bit} + {1'b0, i_cfg.tolerance}));
        half_hit  = (({1'b0, sat} + {1'b0, i_cfg.tolerance}) > {1'b0, i_cfg.half_bit}) &&
                    ({1'b0, sat} < ({1'b0, i_cfg.half_bit} + {1'b0, i_cfg.tolerance}));
        addr_next = {1'b0, r_bit_index} + 4'd1;
        cmd_next  = r_bit_index + 3'd1;
    end

    // next state of the frame walk
    always_comb begin
        n_phase       = r_phase;
        n_interval    = r_interval;
        n_bit_index   = r_bit_index;
        n_addr_shift  = r_addr_shift;
        n_cmd_shift   = r_cmd_shift;
        n_toggle_now  = r_toggle_now;
        n_toggle_prev = r_toggle_prev;
        n_rep_cnt     = r_rep_cnt;
        frame_new     = 1'b0;
        repeat_seen   = 1'b0;

        if (i_fire) begin
            n_interval = sat;
            if (!(eff_phase inside {rc5_dec_pkg::PH_START2, rc5_dec_pkg::PH_TOGGLE,
                                    rc5_dec_pkg::PH_ADDR, rc5_dec_pkg::PH_CMD})) begin
                // waiting for the first start bit
                n_phase = rc5_dec_pkg::PH_IDLE;
                if (i_level_low) begin
                    n_phase    = rc5_dec_pkg::PH_START2;
                    n_interval = '0;
                end
            end else if (!full_hit) begin
                // half bit only resyncs, anything else drops the frame
                if (half_hit) begin
                    n_interval = i_cfg.half_bit;
                end else begin
                    n_phase = rc5_dec_pkg::PH_IDLE;
                end
            end else begin
                n_interval = '0;
                case (eff_phase)
                    rc5_dec_pkg::PH_START2: begin
                        n_phase = rc5_dec_pkg::PH_TOGGLE;
                    end
                    rc5_dec_pkg::PH_TOGGLE: begin
                        n_toggle_prev = r_toggle_now;
                        n_toggle_now  = i_level_low;
                        n_bit_index   = '0;
                        n_addr_shift  = '0;
                        n_cmd_shift   = '0;
                        n_phase       = rc5_dec_pkg::PH_ADDR;
                    end
                    rc5_dec_pkg::PH_ADDR: begin
                        if (i_level_low && (r_bit_index < 3'(rc5_dec_pkg::ADDR_BITS))) begin
                            n_addr_shift[3'(rc5_dec_pkg::ADDR_BITS - 1) - r_bit_index] = 1'b1;
                        end
                        n_bit_index = addr_next[2:0];
                        if (addr_next >= 4'(rc5_dec_pkg::ADDR_BITS)) begin
                            n_bit_index = '0;
                            n_phase     = rc5_dec_pkg::PH_CMD;
                        end
                    end
                    rc5_dec_pkg::PH_CMD: begin
                        if (i_level_low && (r_bit_index < 3'(rc5_dec_pkg::CMD_BITS))) begin
                            n_cmd_shift[3'(rc5_dec_pkg::CMD_BITS - 1) - r_bit_index] = 1'b1;
                        end
                        n_bit_index = cmd_next;
                        if (cmd_next >= 3'(rc5_dec_pkg::CMD_BITS)) begin
                            // frame complete: repeat or new frame
                            n_bit_index = '0;
                            n_phase     = rc5_dec_pkg::PH_IDLE;
                            if ((r_toggle_now == r_toggle_prev) && !i_cfg.rep_dis) begin
                                n_rep_cnt   = r_rep_cnt + 1'b1;
                                repeat_seen = 1'b1;
                            end else begin
                                n_rep_cnt = '0;
                                frame_new = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = rc5_dec_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_evt.frame_new    = frame_new;
    assign o_evt.repeat_seen  = repeat_seen;
    assign o_evt.frame        = {n_addr_shift, n_cmd_shift};
    assign o_evt.repeat_count = n_rep_cnt;

endmodule

>>> hw/rtl/rc5_dec_outq.sv
`timescale 1ns / 1ps

module rc5_dec_outq (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  rc5_dec_pkg::t_result                 i_res,
    input  logic [rc5_dec_pkg::FRAME_W-1:0]      i_rdata,
    input  logic                                 i_stall,
    output logic                                 o_ready,
    output logic                                 o_valid,
    output rc5_dec_pkg::t_result                 o_res,
    output logic [rc5_dec_pkg::ADDR_BITS-1:0]    o_address,
    output logic [rc5_dec_pkg::CMD_BITS-1:0]     o_command
);

    localparam int CW = rc5_dec_pkg::CMD_BITS;

    logic                                r_s1_valid;
    rc5_dec_pkg::t_result                r_s1_res;
    logic                                r_out_valid;
    rc5_dec_pkg::t_result                r_out_res;
    logic [rc5_dec_pkg::ADDR_BITS-1:0]   r_out_address;
    logic [CW-1:0]                       r_out_command;
    logic                                move;

    // stage one drains when the output slot is free or being taken
    assign move    = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_ready = !r_s1_valid || move;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload; popped frame fields read as zero unless the read hit
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s1_res <= i_res;
        end
        if (move) begin
            r_out_res     <= r_s1_res;
            r_out_address <= r_s1_res.read_valid ? i_rdata[rc5_dec_pkg::FRAME_W-1:CW] : '0;
            r_out_command <= r_s1_res.read_valid ? i_rdata[CW-1:0] : '0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_res     = r_out_res;
    assign o_address = r_out_address;
    assign o_command = r_out_command;

endmodule

>>> hw/rtl/rc5_dec_checker.sv
`timescale 1ns / 1ps
`include "rc5_ir_frame_decoder_top_assert.svh"

module rc5_dec_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic                                   o_frame_stored,
    input logic                                   o_repeat_seen,
    input logic                                   o_read_valid,
    input logic [rc5_dec_pkg::ADDR_BITS-1:0]      o_address,
    input logic [rc5_dec_pkg::CMD_BITS-1:0]       o_command,
    input logic [rc5_dec_pkg::CNT_W-1:0]          o_repeat_count
);

    // a beat is either a read result or an edge result, never both
    `RC5_ASSERT_IMP(a_read_xor_edge, i_clk, i_rst_n, o_valid && o_read_valid, !o_frame_stored && !o_repeat_seen, "read beat carries edge flags")

    // a completed frame is either new or a repeat
    `RC5_ASSERT_IMP(a_new_xor_rep, i_clk, i_rst_n, o_valid, !(o_frame_stored && o_repeat_seen), "frame both stored and repeat")

    // popped fields are zero unless the read hit
    `RC5_ASSERT_IMP(a_fields_zero, i_clk, i_rst_n, o_valid && !o_read_valid, (o_address == '0) && (o_command == '0), "frame fields set without a read")

    // a new frame restarts the repeat count
    `RC5_ASSERT_IMP(a_new_frame, i_clk, i_rst_n, o_valid && o_frame_stored, o_repeat_count == '0, "new frame with stale count")

    // a stalled result beat holds
    `RC5_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_repeat_count) && $stable(o_address) && $stable(o_command), "stalled beat changed")

endmodule

bind rc5_ir_frame_decoder_top rc5_dec_checker u_rc5_dec_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int FIFO_DEPTH    = 8;
    localparam int TIMEOUT_TICKS = 13056;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int MAX_REPORTS   = 10;

    localparam int TICK_W    = rc5_dec_pkg::TICK_W;
    localparam int ADDR_BITS = rc5_dec_pkg::ADDR_BITS;
    localparam int CMD_BITS  = rc5_dec_pkg::CMD_BITS;
    localparam int FRAME_W   = rc5_dec_pkg::FRAME_W;
    localparam int CNT_W     = rc5_dec_pkg::CNT_W;
    localparam int CFG_IDX_W = rc5_dec_pkg::CFG_IDX_W;

    // one input beat as queued for the driver
    typedef struct packed {
        logic              kind;
        logic [TICK_W-1:0] elapsed;
        logic              low;
    } t_item;

    // one result beat, in output port order
    typedef struct packed {
        logic                 frame_stored;
        logic                 repeat_seen;
        logic                 read_valid;
        logic [ADDR_BITS-1:0] address;
        logic [CMD_BITS-1:0]  command;
        logic                 fifo_nonempty;
        logic [CNT_W-1:0]     repeat_count;
    } t_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_kind;
    logic [TICK_W-1:0]    i_elapsed_ticks;
    logic                 i_level_low;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_frame_stored;
    logic                 o_repeat_seen;
    logic                 o_read_valid;
    logic [ADDR_BITS-1:0] o_address;
    logic [CMD_BITS-1:0]  o_command;
    logic                 o_fifo_nonempty;
    logic [CNT_W-1:0]     o_repeat_count;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TICK_W-1:0]    i_cfg_wdata;

    rc5_ir_frame_decoder_top #(
        .FIFO_DEPTH    (FIFO_DEPTH),
        .TIMEOUT_TICKS (TIMEOUT_TICKS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_elapsed_ticks (i_elapsed_ticks),
        .i_level_low     (i_level_low),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_frame_stored  (o_frame_stored),
        .o_repeat_seen   (o_repeat_seen),
        .o_read_valid    (o_read_valid),
        .o_address       (o_address),
        .o_command       (o_command),
        .o_fifo_nonempty (o_fifo_nonempty),
        .o_repeat_count  (o_repeat_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // clock: 10 ns period
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_item items_todo[$];
    t_beat beats_due[$];
    int    n_queued   = 0;
    int    mismatches = 0;

    // decoder copy: configuration
    int cfg_half    = 111;
    int cfg_full    = 222;
    int cfg_tol     = 32;
    int cfg_rep_dis = 0;

    // decoder copy: state
    rc5_dec_pkg::t_phase  dec_phase    = rc5_dec_pkg::PH_IDLE;
    logic [TICK_W-1:0]    dec_interval = '0;
    int                   bit_idx      = 0;
    logic [ADDR_BITS-1:0] addr_sh      = '0;
    logic [CMD_BITS-1:0]  cmd_sh       = '0;
    logic                 tog_now      = 1'b0;
    logic                 tog_prev     = 1'b0;
    logic [CNT_W-1:0]     rep_cnt      = '0;
    logic [FRAME_W-1:0]   frame_mem [FIFO_DEPTH];
    int                   rd_ptr       = 0;
    int                   wr_ptr       = 0;

    function automatic logic near_period(input int value, input int nominal);
        return (value + cfg_tol > nominal) && (value < nominal + cfg_tol);
    endfunction

    // advance the decoder copy by one accepted beat and queue its result
    task automatic decode_beat(input logic kind, input logic [TICK_W-1:0] elapsed,
                               input logic low);
        t_beat r;
        int    sum;
        r = '0;
        if (kind == rc5_dec_pkg::KIND_EDGE) begin
            if (int'(elapsed) >= TIMEOUT_TICKS) dec_phase = rc5_dec_pkg::PH_IDLE;
            sum = int'(dec_interval) + int'(elapsed);
            if (sum > 65535) sum = 65535;
            dec_interval = sum[TICK_W-1:0];
            if (dec_phase == rc5_dec_pkg::PH_IDLE) begin
                if (low) begin
                    dec_phase    = rc5_dec_pkg::PH_START2;
                    dec_interval = '0;
                end
            end else if (!near_period(int'(dec_interval), cfg_full)) begin
                if (near_period(int'(dec_interval), cfg_half))
                    dec_interval = cfg_half[TICK_W-1:0];
                else
                    dec_phase = rc5_dec_pkg::PH_IDLE;
            end else begin
                dec_interval = '0;
                case (dec_phase)
                    rc5_dec_pkg::PH_START2: dec_phase = rc5_dec_pkg::PH_TOGGLE;
                    rc5_dec_pkg::PH_TOGGLE: begin
                        tog_prev  = tog_now;
                        tog_now   = low;
                        bit_idx   = 0;
                        addr_sh   = '0;
                        cmd_sh    = '0;
                        dec_phase = rc5_dec_pkg::PH_ADDR;
                    end
                    rc5_dec_pkg::PH_ADDR: begin
                        if (low) addr_sh[ADDR_BITS-1-bit_idx] = 1'b1;
                        bit_idx++;
                        if (bit_idx >= ADDR_BITS) begin
                            bit_idx   = 0;
                            dec_phase = rc5_dec_pkg::PH_CMD;
                        end
                    end
                    default: begin
                        if (low) cmd_sh[CMD_BITS-1-bit_idx] = 1'b1;
                        bit_idx++;
                        if (bit_idx >= CMD_BITS) begin
                            bit_idx = 0;
                            if (tog_now == tog_prev && cfg_rep_dis == 0) begin
                                rep_cnt       = rep_cnt + 1'b1;
                                r.repeat_seen = 1'b1;
                            end else begin
                                frame_mem[wr_ptr] = {addr_sh, cmd_sh};
                                wr_ptr            = (wr_ptr + 1) % FIFO_DEPTH;
                                rep_cnt           = '0;
                                r.frame_stored    = 1'b1;
                            end
                            dec_phase = rc5_dec_pkg::PH_IDLE;
                        end
                    end
                endcase
            end
        end else if (rd_ptr != wr_ptr) begin
            r.read_valid           = 1'b1;
            {r.address, r.command} = frame_mem[rd_ptr];
            rd_ptr                 = (rd_ptr + 1) % FIFO_DEPTH;
        end
        r.fifo_nonempty = (rd_ptr != wr_ptr);
        r.repeat_count  = rep_cnt;
        beats_due.push_back(r);
    endtask

    // ---------------- stimulus helpers ----------------

    task automatic push_edge(input int elapsed, input logic low);
        t_item it;
        if (elapsed < 0) elapsed = 0;
        if (elapsed > 65535) elapsed = 65535;
        it.kind    = rc5_dec_pkg::KIND_EDGE;
        it.elapsed = elapsed[TICK_W-1:0];
        it.low     = low;
        items_todo.push_back(it);
        n_queued++;
    endtask

    // read beats carry random unused payload so all bits still toggle
    task automatic push_read();
        t_item it;
        it.kind    = rc5_dec_pkg::KIND_READ;
        it.elapsed = TICK_W'($urandom_range(0, 65535));
        it.low     = 1'($urandom_range(0, 1));
        items_todo.push_back(it);
        n_queued++;
    endtask

    // period around nominal, now and then just outside the tolerance
    function automatic int wobble(input int nominal);
        int span;
        span = (cfg_tol > 200) ? 200 : cfg_tol - 1;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? nominal + cfg_tol : nominal - cfg_tol;
        return nominal - span + int'($urandom_range(0, 2 * span));
    endfunction

    // one Manchester bit: a full period, or two halves
    task automatic push_bit(input logic level);
        if (cfg_full > cfg_half && $urandom_range(0, 2) == 0) begin
            push_edge(wobble(cfg_half), 1'($urandom_range(0, 1)));
            push_edge(wobble(cfg_full - cfg_half), level);
        end else begin
            push_edge(wobble(cfg_full), level);
        end
    endtask

    task automatic push_noise();
        int nominal;
        case ($urandom_range(0, 3))
            0: push_edge($urandom_range(0, 65535), 1'($urandom_range(0, 1)));
            1: begin
                // right at the tolerance boundary
                nominal = $urandom_range(0, 1) ? cfg_full : cfg_half;
                push_edge(nominal + ($urandom_range(0, 1) ? 1 : -1) *
                          (cfg_tol - int'($urandom_range(0, 1))),
                          1'($urandom_range(0, 1)));
            end
            2: push_edge($urandom_range(0, 31), 1'($urandom_range(0, 1)));
            default: push_edge(TIMEOUT_TICKS - 1 + int'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
        endcase
    endtask

    // full frame: start edge, second start bit, toggle, address, command
    task automatic push_frame(input logic [ADDR_BITS-1:0] addr,
                              input logic [CMD_BITS-1:0] cmd,
                              input logic tog, input logic broken);
        int   cut;
        logic v;
        cut = broken ? $urandom_range(0, 12) : 99;
        if ($urandom_range(0, 1))
            push_edge(TIMEOUT_TICKS + int'($urandom_range(0, 65535 - TIMEOUT_TICKS)), 1'b1);
        else
            push_edge($urandom_range(0, 400), 1'b1);
        for (int b = 0; b < 13; b++) begin
            if (b == cut) push_noise();
            if (b == 0)      v = 1'($urandom_range(0, 1));
            else if (b == 1) v = tog;
            else if (b < 7)  v = addr[6-b];
            else             v = cmd[12-b];
            push_bit(v);
        end
    endtask

    task automatic fill_random(input int quota);
        int read_pct;
        int r;
        read_pct = $urandom_range(0, 1) ? 50 : 8;
        n_queued = 0;
        while (n_queued < quota) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                push_frame(ADDR_BITS'($urandom), CMD_BITS'($urandom),
                           1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
                if ($urandom_range(0, 99) < read_pct) push_read();
            end else if (r < 82) begin
                repeat ($urandom_range(1, 3)) push_read();
            end else begin
                repeat ($urandom_range(1, 3)) push_noise();
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value[TICK_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            rc5_dec_pkg::REG_HALF_BIT:  cfg_half    = value & 16'hFFFF;
            rc5_dec_pkg::REG_FULL_BIT:  cfg_full    = value & 16'hFFFF;
            rc5_dec_pkg::REG_TOLERANCE: cfg_tol     = value & 16'hFFFF;
            default:                    cfg_rep_dis = value & 1;
        endcase
    endtask

    task automatic set_cfg(input int half, input int full, input int tol, input int rep_dis);
        write_reg(rc5_dec_pkg::REG_HALF_BIT, half);
        write_reg(rc5_dec_pkg::REG_FULL_BIT, full);
        write_reg(rc5_dec_pkg::REG_TOLERANCE, tol);
        write_reg(rc5_dec_pkg::REG_REP_DIS, rep_dis);
    endtask

    // hold until every queued beat went in and every result came out
    task automatic settle();
        while (items_todo.size() != 0 || i_valid || beats_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------- idle and stall patterns ----------------

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    logic  in_taken   = 1'b0;
    int    gap_left   = 0;
    int    stall_left = 0;
    logic  send_burst = 1'b0;
    logic  recv_burst = 1'b0;
    t_item next_item;
    t_beat got, want;

    // input driver: new beat only once the previous one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (items_todo.size() != 0) begin
                next_item = items_todo.pop_front();
                i_kind          <= next_item.kind;
                i_elapsed_ticks <= next_item.elapsed;
                i_level_low     <= next_item.low;
                i_valid         <= 1'b1;
                if ($urandom_range(0, 79) == 0) send_burst = !send_burst;
                gap_left = send_burst ? 0 : draw_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            if ($urandom_range(0, 79) == 0) recv_burst = !recv_burst;
            stall_left = recv_burst ? 0 : draw_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // accepted input beats feed the prediction; result beats are checked
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) decode_beat(i_kind, i_elapsed_ticks, i_level_low);
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_frame_stored, o_repeat_seen, o_read_valid, o_address, o_command,
                   o_fifo_nonempty, o_repeat_count};
            if (beats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: result beat with nothing pending at %0t", $realtime);
            end else begin
                want = beats_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("tb: mismatch at %0t", $realtime);
                        $display("  exp fs=%b rs=%b rv=%b a=%0d c=%0d ne=%b rc=%0d",
                                 want.frame_stored, want.repeat_seen, want.read_valid,
                                 want.address, want.command, want.fifo_nonempty,
                                 want.repeat_count);
                        $display("  got fs=%b rs=%b rv=%b a=%0d c=%0d ne=%b rc=%0d",
                                 got.frame_stored, got.repeat_seen, got.read_valid,
                                 got.address, got.command, got.fifo_nonempty,
                                 got.repeat_count);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: FAIL");
        $finish;
    end

    // ---------------- test sequence ----------------
    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_kind          = rc5_dec_pkg::KIND_EDGE;
        i_elapsed_ticks = '0;
        i_level_low     = 1'b0;
        i_stall         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = rc5_dec_pkg::REG_HALF_BIT;
        i_cfg_wdata     = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset config: read on empty FIFO
        push_read();
        // saturating timeout edge starts a frame; second start bit as two halves
        push_edge(65535, 1'b1);
        push_edge(111, 1'b0);
        push_edge(111, 1'b0);
        // toggle 0 just inside the upper tolerance: first frame counts as a repeat
        push_edge(253, 1'b0);
        repeat (11) push_edge(222, 1'b1);
        push_read();
        // exact timeout starts again, start bit just inside lower tolerance
        push_edge(TIMEOUT_TICKS, 1'b1);
        push_edge(191, 1'b1);
        push_edge(222, 1'b1);
        repeat (11) push_edge(222, 1'b0);
        // pop the stored frame, then read empty again
        push_read();
        push_read();
        settle();

        fill_random(160);
        settle();

        set_cfg(1, 2, 1, 1);
        fill_random(160);
        settle();

        set_cfg(889, 1778, 50, 0);
        fill_random(160);
        settle();

        set_cfg(65535, 65535, 65535, 1);
        fill_random(160);
        settle();

        set_cfg(3000, 6000, 400, 0);
        fill_random(160);
        settle();

        set_cfg(111, 222, 32, 0);
        fill_random(160);
        settle();

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rc5_dec_pkg.sv
hw/rtl/rc5_dec_ram.sv
hw/rtl/rc5_dec_core.sv
hw/rtl/rc5_dec_outq.sv
hw/rtl/rc5_ir_frame_decoder_top.sv
hw/rtl/rc5_dec_checker.sv
bench/tb.sv
